// File: sv/assert_macros.svh
// Assertion macros for the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define TWM_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define TWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/twm_pkg.sv
// Shared constants and types of the topic wildcard matcher.
package twm_pkg;

    localparam int MAX_LEN = 255;
    localparam int CELLS   = MAX_LEN + 1;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int PA_W    = $clog2(MAX_LEN);

    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_HASH = 8'h23;

    typedef enum logic [1:0] {
        CMD_PAT_APPEND = 2'd0,
        CMD_PAT_END    = 2'd1,
        CMD_KEY_APPEND = 2'd2,
        CMD_EVAL       = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_INIT,
        OP_LIT,
        OP_EOW,
        OP_STAR,
        OP_HASH,
        OP_HASH_DONE
    } cell_op_t;

    typedef struct packed {
        cell_op_t   op;
        logic [7:0] cbyte;
    } cell_ctrl_t;

    typedef struct packed {
        logic move;
        logic dot;
    } cell_link_t;

endpackage

// File: sv/twm_cell.sv
// One key position: key byte, match token and hand-off to the right neighbor.
module twm_cell
    import twm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       key_wr,
    input  logic [7:0] key_byte,
    input  logic       lt,
    input  logic       eq,
    input  cell_link_t left,
    output cell_link_t right,
    output logic       hit
);

    logic [7:0] kb_reg;
    logic       tok_reg;
    logic       tok_next;
    logic       dot;
    logic       wend;

    assign dot  = (kb_reg == CH_DOT);
    assign wend = eq | (lt & dot);
    assign hit  = tok_reg & eq;

    always_comb
    begin
        right.dot = lt & dot;
        unique case (ctrl.op)
            OP_LIT:  right.move = tok_reg & lt & (kb_reg == ctrl.cbyte);
            OP_EOW:  right.move = tok_reg & lt & dot;
            OP_STAR: right.move = tok_reg & lt & ~dot;
            OP_HASH: right.move = tok_reg & lt;
            default: right.move = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.op)
            OP_INIT, OP_LIT, OP_EOW: tok_next = left.move;
            OP_STAR:                 tok_next = (tok_reg & wend) | left.move;
            OP_HASH:                 tok_next = tok_reg | left.move;
            OP_HASH_DONE:            tok_next = tok_reg & left.dot;
            default:                 tok_next = tok_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_wr)
        begin
            kb_reg <= key_byte;
        end
    end

endmodule

// File: sv/twm_pbuf.sv
// Pattern byte store, one write and one registered read port.
module twm_pbuf
    import twm_pkg::*;
(
    input  logic            clk,
    input  logic            wr_en,
    input  logic [PA_W-1:0] wr_addr,
    input  logic [7:0]      wr_data,
    input  logic [PA_W-1:0] rd_addr,
    output logic [7:0]      rd_data
);

    logic [7:0] mem [MAX_LEN];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: sv/topic_wildcard_matcher.sv
// Topic wildcard matcher top level: request handling, evaluation sequencer, cell row.
// Append requests are absorbed in the idle state; an evaluate request walks the pattern
// store one byte per step and moves match tokens along the cell row, where each '*' or '#'
// word sweeps the whole key. An overflowed request goes straight to the result state.
// One request is in work at a time.
// rst_n clears all control state asynchronously; the empty pattern is committed.
module topic_wildcard_matcher
    import twm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    input  logic [1:0] s_tuser,   // [1:0] command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [1] too_long, [7:2] zero
);

`include "assert_macros.svh"

    // Sequencer states.
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RD    = 8'b0000_0010,  // issue read of pattern byte p
        S_DAT   = 8'b0000_0100,  // byte p on read data
        S_LOOK  = 8'b0000_1000,  // byte p+1 on read data, classify wildcard
        S_STAR  = 8'b0001_0000,  // walk tokens to word ends
        S_HASH  = 8'b0010_0000,  // smear tokens to the right
        S_HDONE = 8'b0100_0000,  // keep tokens on word starts only
        S_FIN   = 8'b1000_0000   // hand result to output register
    } state_t;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] pat_len_reg, pat_len_next;
    logic             pat_cmt_reg, pat_cmt_next;
    logic             pat_ovf_reg, pat_ovf_next;
    logic [LEN_W-1:0] key_len_reg, key_len_next;
    logic             key_ovf_reg, key_ovf_next;
    logic [LEN_W-1:0] p_reg, p_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             ws_reg, ws_next;      // at start of a pattern word
    logic             hskip_reg, hskip_next; // last word was '#': no end-of-word step
    logic             end_reg, end_next;    // token past the last key word
    logic             tl_reg, tl_next;
    logic [7:0]       cur_reg, cur_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_match_reg, m_match_next;
    logic             m_tl_reg, m_tl_next;

    logic             accept;
    cmd_t             cmd;
    logic [LEN_W-1:0] pat_eff;
    logic             pat_wr;
    logic             key_wr;
    logic [PA_W-1:0]  rd_addr;
    logic [7:0]       rd_data;
    cell_ctrl_t       ctrl;
    logic             hit_any;
    logic             special;

    logic [CELLS-1:0] hit;
    cell_link_t       link [CELLS+1];

    assign accept   = s_tvalid & s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_tl_reg, m_match_reg};
    assign hit_any  = |hit;

    // a new pattern restarts at zero when the previous one was committed
    assign pat_eff = pat_cmt_reg ? '0 : pat_len_reg;
    assign pat_wr  = accept && (cmd == CMD_PAT_APPEND) && (pat_eff < LEN_W'(MAX_LEN));
    assign key_wr  = accept && (cmd == CMD_KEY_APPEND) && (key_len_reg < LEN_W'(MAX_LEN));
    assign special = ((p_reg + 1'b1) == pat_len_reg) || (rd_data == CH_DOT);

    twm_pbuf u_pbuf (
        .clk     (clk),
        .wr_en   (pat_wr),
        .wr_addr (pat_eff[PA_W-1:0]),
        .wr_data (s_tdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Cell row: cell i is key byte i; cell key_len is the position after the key.
    assign link[0] = '{move: (ctrl.op == OP_INIT), dot: 1'b1};

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        twm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .key_wr   (key_wr && (key_len_reg == LEN_W'(i))),
            .key_byte (s_tdata),
            .lt       (LEN_W'(i) < key_len_reg),
            .eq       (LEN_W'(i) == key_len_reg),
            .left     (link[i]),
            .right    (link[i+1]),
            .hit      (hit[i])
        );
    end

    always_comb
    begin
        state_next   = state_reg;
        pat_len_next = pat_len_reg;
        pat_cmt_next = pat_cmt_reg;
        pat_ovf_next = pat_ovf_reg;
        key_len_next = key_len_reg;
        key_ovf_next = key_ovf_reg;
        p_next       = p_reg;
        cnt_next     = cnt_reg;
        ws_next      = ws_reg;
        hskip_next   = hskip_reg;
        end_next     = end_reg;
        tl_next      = tl_reg;
        cur_next     = cur_reg;
        m_valid_next = m_valid_reg;
        m_match_next = m_match_reg;
        m_tl_next    = m_tl_reg;
        rd_addr      = p_reg[PA_W-1:0];
        ctrl.op      = OP_NOP;
        ctrl.cbyte   = rd_data;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_PAT_APPEND:
                        begin
                            pat_cmt_next = 1'b0;
                            if (pat_cmt_reg)
                            begin
                                pat_ovf_next = 1'b0;
                            end
                            if (pat_eff < LEN_W'(MAX_LEN))
                            begin
                                pat_len_next = pat_eff + 1'b1;
                            end
                            else
                            begin
                                pat_len_next = pat_eff;
                                pat_ovf_next = 1'b1;
                            end
                        end
                        CMD_PAT_END:
                        begin
                            if (pat_cmt_reg)
                            begin
                                pat_len_next = '0;
                                pat_ovf_next = 1'b0;
                            end
                            pat_cmt_next = 1'b1;
                        end
                        CMD_KEY_APPEND:
                        begin
                            if (key_len_reg < LEN_W'(MAX_LEN))
                            begin
                                key_len_next = key_len_reg + 1'b1;
                            end
                            else
                            begin
                                key_ovf_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            tl_next = pat_ovf_reg | key_ovf_reg;
                            if (pat_ovf_reg | key_ovf_reg)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                ctrl.op    = OP_INIT;
                                end_next   = 1'b0;
                                p_next     = '0;
                                ws_next    = 1'b1;
                                hskip_next = 1'b0;
                                state_next = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_RD:
            begin
                if (p_reg == pat_len_reg)
                begin
                    // end of pattern closes the last word
                    if (!hskip_reg)
                    begin
                        ctrl.op  = OP_EOW;
                        end_next = hit_any;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DAT;
                end
            end
            S_DAT:
            begin
                priority if (rd_data == CH_DOT)
                begin
                    if (!hskip_reg)
                    begin
                        ctrl.op  = OP_EOW;
                        end_next = hit_any;
                    end
                    hskip_next = 1'b0;
                    ws_next    = 1'b1;
                    p_next     = p_reg + 1'b1;
                    state_next = S_RD;
                end
                else if (ws_reg && ((rd_data == CH_STAR) || (rd_data == CH_HASH)))
                begin
                    cur_next   = rd_data;
                    rd_addr    = PA_W'(p_reg + 1'b1);
                    state_next = S_LOOK;
                end
                else
                begin
                    ctrl.op    = OP_LIT;
                    end_next   = 1'b0;
                    ws_next    = 1'b0;
                    p_next     = p_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_LOOK:
            begin
                ws_next = 1'b0;
                p_next  = p_reg + 1'b1;
                if (special)
                begin
                    cnt_next   = '0;
                    state_next = (cur_reg == CH_STAR) ? S_STAR : S_HASH;
                end
                else
                begin
                    // wildcard char inside a longer word is a plain byte
                    ctrl.op    = OP_LIT;
                    ctrl.cbyte = cur_reg;
                    end_next   = 1'b0;
                    state_next = S_RD;
                end
            end
            S_STAR:
            begin
                ctrl.op  = OP_STAR;
                end_next = 1'b0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == key_len_reg)
                begin
                    state_next = S_RD;
                end
            end
            S_HASH:
            begin
                ctrl.op  = OP_HASH;
                end_next = end_reg | hit_any;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == key_len_reg)
                begin
                    state_next = S_HDONE;
                end
            end
            S_HDONE:
            begin
                ctrl.op    = OP_HASH_DONE;
                hskip_next = 1'b1;
                state_next = S_RD;
            end
            S_FIN:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_match_next = end_reg & ~tl_reg;
                    m_tl_next    = tl_reg;
                    key_len_next = '0;
                    key_ovf_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pat_len_reg <= '0;
            pat_cmt_reg <= 1'b1;
            pat_ovf_reg <= 1'b0;
            key_len_reg <= '0;
            key_ovf_reg <= 1'b0;
            p_reg       <= '0;
            cnt_reg     <= '0;
            ws_reg      <= 1'b0;
            hskip_reg   <= 1'b0;
            end_reg     <= 1'b0;
            tl_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pat_len_reg <= pat_len_next;
            pat_cmt_reg <= pat_cmt_next;
            pat_ovf_reg <= pat_ovf_next;
            key_len_reg <= key_len_next;
            key_ovf_reg <= key_ovf_next;
            p_reg       <= p_next;
            cnt_reg     <= cnt_next;
            ws_reg      <= ws_next;
            hskip_reg   <= hskip_next;
            end_reg     <= end_next;
            tl_reg      <= tl_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        m_match_reg <= m_match_next;
        m_tl_reg    <= m_tl_next;
    end

    `TWM_ASSERT(a_key_len, key_len_reg <= LEN_W'(MAX_LEN), "key length past MAX_LEN")
    `TWM_ASSERT(a_pat_len, pat_len_reg <= LEN_W'(MAX_LEN), "pattern length past MAX_LEN")
    `TWM_ASSERT(a_key_ovf, !key_ovf_reg || (key_len_reg == LEN_W'(MAX_LEN)), "early key overflow")
    `TWM_ASSERT_NEXT(a_eval_busy, accept && (cmd == CMD_EVAL), !s_tready, "ready during evaluation")

endmodule

// File: test/twm_checker.sv
// Checker for the topic wildcard matcher: predicts each evaluate result and compares.
`timescale 1ns / 100ps
module twm_checker
    import twm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic [1:0] s_tuser,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    output int         fail_count,
    output int         pending,
    output int         verdicts_seen,
    output int         matches_seen
);

    typedef struct packed {
        logic too_long;
        logic matched;
    } verdict_t;

    logic [7:0] pat_bytes [MAX_LEN];
    logic [7:0] key_bytes [MAX_LEN];
    int         pat_len;
    logic       pat_done;
    logic       pat_ovf;
    int         key_len;
    logic       key_ovf;
    verdict_t   verdict_q [$];

    task automatic report(input string what);
        $display("checker: mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Split a buffer into word start/length lists; empty words count.
    function automatic int word_spans(input logic [7:0] buf_b [MAX_LEN], input int n,
                                      ref int st [], ref int ln []);
        int cnt;
        int beg;
        cnt = 0;
        beg = 0;
        st = new[n + 1];
        ln = new[n + 1];
        for (int i = 0; i < n; i++)
            if (buf_b[i] == CH_DOT)
            begin
                st[cnt] = beg;
                ln[cnt] = i - beg;
                cnt++;
                beg = i + 1;
            end
        st[cnt] = beg;
        ln[cnt] = n - beg;
        return cnt + 1;
    endfunction

    // Dynamic program over words, last pattern word first.
    function automatic logic topic_matches();
        int  ps [];
        int  pl [];
        int  ks [];
        int  kl [];
        int  np;
        int  nk;
        bit  reach [];
        bit  star;
        bit  ok;
        np = word_spans(pat_bytes, pat_len, ps, pl);
        nk = word_spans(key_bytes, key_len, ks, kl);
        reach = new[nk + 1];
        for (int k = 0; k <= nk; k++)
            reach[k] = (k == nk);
        for (int p = np - 1; p >= 0; p--)
        begin
            if (pl[p] == 1 && pat_bytes[ps[p]] == CH_HASH)
            begin
                for (int k = nk - 1; k >= 0; k--)
                    reach[k] = reach[k] | reach[k + 1];
            end
            else
            begin
                star = (pl[p] == 1 && pat_bytes[ps[p]] == CH_STAR);
                for (int k = 0; k < nk; k++)
                begin
                    ok = star || (pl[p] == kl[k]);
                    if (!star && ok)
                        for (int j = 0; j < pl[p]; j++)
                            if (pat_bytes[ps[p] + j] != key_bytes[ks[k] + j])
                                ok = 0;
                    reach[k] = ok && reach[k + 1];
                end
                reach[nk] = 0;
            end
        end
        return reach[0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t v;
        verdict_t got;
        if (!rst_n)
        begin
            pat_len  = 0;
            pat_done = 1;
            pat_ovf  = 0;
            key_len  = 0;
            key_ovf  = 0;
            verdict_q.delete();
            fail_count    <= 0;
            verdicts_seen <= 0;
            matches_seen  <= 0;
            pending       <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[1:0];
                verdicts_seen <= verdicts_seen + 1;
                if (m_tdata[0])
                    matches_seen <= matches_seen + 1;
                if (verdict_q.size() == 0)
                    report("result with nothing expected");
                else
                begin
                    v = verdict_q.pop_front();
                    if (got.matched !== v.matched)
                        report($sformatf("matched %b, expected %b", got.matched, v.matched));
                    if (got.too_long !== v.too_long)
                        report($sformatf("too_long %b, expected %b",
                                         got.too_long, v.too_long));
                    if (m_tdata[7:2] !== 6'd0)
                        report("nonzero pad bits");
                end
            end
            if (s_tvalid && s_tready)
            begin
                case (cmd_t'(s_tuser))
                    CMD_PAT_APPEND:
                    begin
                        if (pat_done)
                        begin
                            pat_done = 0;
                            pat_len  = 0;
                            pat_ovf  = 0;
                        end
                        if (pat_len < MAX_LEN)
                            pat_bytes[pat_len++] = s_tdata;
                        else
                            pat_ovf = 1;
                    end
                    CMD_PAT_END:
                    begin
                        if (pat_done)
                        begin
                            pat_len = 0;
                            pat_ovf = 0;
                        end
                        pat_done = 1;
                    end
                    CMD_KEY_APPEND:
                    begin
                        if (key_len < MAX_LEN)
                            key_bytes[key_len++] = s_tdata;
                        else
                            key_ovf = 1;
                    end
                    default:
                    begin
                        v.too_long = pat_ovf | key_ovf;
                        v.matched  = v.too_long ? 1'b0 : topic_matches();
                        verdict_q.push_back(v);
                        key_len = 0;
                        key_ovf = 0;
                    end
                endcase
            end
            pending <= verdict_q.size();
        end
    end

endmodule

// File: test/tb.sv
// Testbench top for the topic wildcard matcher: stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb
    import twm_pkg::*;
();

    localparam int CYCLE_LIMIT = 3_000_000;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [1:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    int         fail_count;
    int         pending;
    int         verdicts_seen;
    int         matches_seen;
    int         requests_sent;
    int         cycle_count;

    topic_wildcard_matcher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    twm_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .verdicts_seen (verdicts_seen),
        .matches_seen  (matches_seen)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side stall pattern.
    initial
    begin
        int g;
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            g = gap_len();
            if (g > 0)
            begin
                m_tready <= 0;
                repeat (g) @(posedge clk);
            end
            m_tready <= 1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // One request: optional gap first, then hold valid until accepted.
    task automatic send(input cmd_t cmd, input logic [7:0] ch);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= ch;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic send_string(input cmd_t cmd, input string s);
        for (int i = 0; i < s.len(); i++)
            send(cmd, s[i]);
    endtask

    task automatic load_pattern(input string s);
        send_string(CMD_PAT_APPEND, s);
        send(CMD_PAT_END, 8'($urandom));
    endtask

    task automatic eval_key(input string s);
        send_string(CMD_KEY_APPEND, s);
        send(CMD_EVAL, 8'($urandom));
    endtask

    // Random word drawn from a tiny alphabet so literal words collide often.
    function automatic string word_str(input bit pat_side);
        string w;
        int    r;
        r = $urandom_range(0, 9);
        if (pat_side && r < 2)
            return "*";
        if (pat_side && r < 4)
            return "#";
        w = "";
        repeat ($urandom_range(0, 2))
            w = {w, string'(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                         : 8'($urandom_range(8'h61, 8'h62)))};
        return w;
    endfunction

    function automatic string topic_str(input bit pat_side, input int nwords);
        string s;
        s = word_str(pat_side);
        for (int i = 1; i < nwords; i++)
            s = {s, ".", word_str(pat_side)};
        return s;
    endfunction

    initial
    begin
        string p;
        string k;
        int    r;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata  = 0;
        s_tuser  = CMD_PAT_APPEND;
        cycle_count = 0;
        requests_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty pattern at reset against empty and nonempty keys.
        eval_key("");
        eval_key("a");
        send(CMD_PAT_END, 8'h00);          // end pattern with no bytes
        eval_key("");
        load_pattern("#");
        eval_key("a.b");
        load_pattern("*.b");
        eval_key("x.b");
        eval_key("b");
        load_pattern("a..#");
        eval_key("a.");
        // Zero byte and all-ones byte are ordinary characters.
        send(CMD_PAT_APPEND, 8'h00);
        send(CMD_PAT_APPEND, ".");
        send(CMD_PAT_APPEND, 8'hFF);
        send(CMD_PAT_END, 8'h00);
        send(CMD_KEY_APPEND, 8'h00);
        send(CMD_KEY_APPEND, ".");
        send(CMD_KEY_APPEND, 8'hFF);
        send(CMD_EVAL, 8'h00);
        // Evaluate while a pattern is still loading.
        send(CMD_PAT_APPEND, "q");
        eval_key("q");
        send(CMD_PAT_END, 8'h00);
        // Overflow of the key, then of the pattern.
        repeat (MAX_LEN + 2) send(CMD_KEY_APPEND, "k");
        send(CMD_EVAL, 8'h00);
        repeat (MAX_LEN + 1) send(CMD_PAT_APPEND, "p");
        send(CMD_PAT_END, 8'h00);
        eval_key("p");
        repeat (MAX_LEN) send(CMD_PAT_APPEND, "#");
        send(CMD_PAT_END, 8'h00);
        eval_key("");

        // Random: mostly well-formed patterns and keys, some raw noise.
        while (requests_sent < 1850)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
                load_pattern(topic_str(1, $urandom_range(1, 4)));
            if (r < 88)
            begin
                k = topic_str(0, $urandom_range(1, 5));
                eval_key(k);
            end
            else
                send(cmd_t'($urandom_range(0, 3)), 8'($urandom));
        end
        s_tvalid <= 0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("tb: %0d requests sent, %0d verdicts checked (%0d matches)",
                 requests_sent, verdicts_seen, matches_seen);
        $display("tb: covered wildcards, empty words, overflow and mid-load evaluation");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
